@@ rtl/ppto_pkg.sv @@
package ppto_pkg;

	localparam int MAX_POSES_DEF = 64;

	localparam int POS_W      = 24;
	localparam int HEAD_W     = 16;
	localparam int CUM_W      = 32;
	localparam int DIFF_W     = 25;
	localparam int SQ_W       = 50;
	localparam int ROOT_W     = 25;
	localparam int CORD_W     = 36;
	localparam int CORD_STEPS = 15;
	localparam int REM_W      = 49;
	localparam int MS_W       = 16;
	localparam int OMNI_W     = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OMNI_COUNT  = 1'd1;

	localparam logic [MS_W-1:0]   MIN_SPACING_RST = 16'd51;
	localparam logic [OMNI_W-1:0] OMNI_COUNT_RST  = 5'd20;

	localparam logic [HEAD_W-1:0] HALF_TURN  = 16'h8000;
	localparam logic [CORD_W-1:0] NORM_FLOOR = 36'h020000000;

	// atan(2^-i) as a binary angle
	function automatic logic [HEAD_W-1:0] atan_step(input logic [3:0] i);
		logic [HEAD_W-1:0] a;
		case (i)
			4'd0:    a = 16'd8192;
			4'd1:    a = 16'd4836;
			4'd2:    a = 16'd2555;
			4'd3:    a = 16'd1297;
			4'd4:    a = 16'd651;
			4'd5:    a = 16'd326;
			4'd6:    a = 16'd163;
			4'd7:    a = 16'd81;
			4'd8:    a = 16'd41;
			4'd9:    a = 16'd20;
			4'd10:   a = 16'd10;
			4'd11:   a = 16'd5;
			4'd12:   a = 16'd3;
			4'd13:   a = 16'd1;
			4'd14:   a = 16'd1;
			default: a = 16'd0;
		endcase
		return a;
	endfunction

	typedef enum logic [4:0] {
		ST_IDLE, ST_DEC, ST_SQ1, ST_SQ2, ST_CMP, ST_SQRT, ST_COMMIT, ST_SINGLE,
		ST_PRE_RA, ST_PRE_CA, ST_PRE_CB, ST_PRE_CORD,
		ST_E_RA, ST_E_CA, ST_E_CB, ST_E_CORD, ST_E_BST, ST_E_DIV, ST_E_LOAD, ST_E_WAIT
	} ctrl_state_t;

	typedef enum logic [1:0] {BL_SHORT, BL_HEAD, BL_TAIL} blend_sel_t;
	typedef enum logic [1:0] {HS_START, HS_GOAL, HS_CORD, HS_BLEND} head_sel_t;
	typedef enum logic [1:0] {CS_IDLE, CS_NORM, CS_ROT} cord_phase_t;
	typedef enum logic [1:0] {BP_IDLE, BP_MUL, BP_DIV} blend_phase_t;

	typedef struct packed {
		logic       cap_in;
		logic       first;
		logic       commit;
		logic       finish;
		logic       single_out;
		logic       sq1;
		logic       sq2;
		logic       sqrt_go;
		logic       cap_a;
		logic       cord_go;
		logic       save_target;
		logic       save_fromr;
		logic       blend_go;
		blend_sel_t bsel;
		logic       load_out;
		head_sel_t  hsel;
		logic       out_end;
	} ppto_cmd_t;

	typedef struct packed {
		logic in_last;
		logic too_close;
		logic sqrt_done;
		logic cord_done;
		logic blend_done;
		logic out_busy;
	} ppto_stat_t;

endpackage

@@ rtl/path_pose_thin_and_orient.sv @@
// flow: a pose discarded on a full store is not measured; one dropped for spacing goes after
// the distance compare; a kept pose waits for the 25-step square root of its distance to the last kept pose
// the last pose then emits every kept pose, one at a time: the ends take the start and goal headings,
// the others a blend or a segment direction (normalize and up to 15 rotations), plus output wait
// throughput: one pose in flight at a time; input is held off until all results are taken
// reset: arst_n clears the controller, the kept count and the output valid at once
module path_pose_thin_and_orient import ppto_pkg::*; #(
	parameter int MAX_POSES = MAX_POSES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// register write port, index 0 min_spacing, index 1 omni_count
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input poses
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [63:0]           s_axis_tdata,  // pos_x[23:0], pos_y[47:24], heading[63:48]
	input  logic                  s_axis_tlast,  // last pose of the path
	// output poses
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [63:0]           m_axis_tdata,  // out_x[23:0], out_y[47:24], out_heading[63:48]
	output logic                  m_axis_tlast   // final emitted pose
);

	localparam int IW = $clog2(MAX_POSES);

	ppto_cmd_t               cmd;
	ppto_stat_t              stat;
	logic [IW-1:0]           wr_addr, rd_addr;
	logic [OMNI_W-1:0]       blend_num, omni_den, omni_count;
	logic signed [POS_W-1:0] out_x, out_y;
	logic [HEAD_W-1:0]       out_heading;

	// controller: loading, thinning, then the emit sweep over the stores
	ppto_ctrl #(.MAX_POSES(MAX_POSES)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.omni_count (omni_count),
		.stat       (stat),
		.cmd        (cmd),
		.wr_addr    (wr_addr),
		.rd_addr    (rd_addr),
		.blend_num  (blend_num),
		.omni_den   (omni_den)
	);

	// datapath: registers, pose stores, square root, direction and blend units,
	// and the output register that holds a result until its transfer
	ppto_dp #(.MAX_POSES(MAX_POSES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_x        (s_axis_tdata[23:0]),
		.in_y        (s_axis_tdata[47:24]),
		.in_h        (s_axis_tdata[63:48]),
		.in_last     (s_axis_tlast),
		.cmd         (cmd),
		.wr_addr     (wr_addr),
		.rd_addr     (rd_addr),
		.blend_num   (blend_num),
		.omni_den    (omni_den),
		.stat        (stat),
		.omni_count  (omni_count),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_heading (out_heading),
		.out_last    (m_axis_tlast),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready)
	);

	assign m_axis_tdata = {out_heading, out_y, out_x};

endmodule

@@ rtl/ppto_isqrt.sv @@
module ppto_isqrt import ppto_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [SQ_W-1:0]   value,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] r_q;
	logic [SQ_W-1:0] bit_q;
	logic [4:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [SQ_W:0]   trial;

	assign trial = {1'b0, r_q} + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	// one result bit per cycle
	always_ff @(posedge clk) begin
		if (go) begin
			v_q   <= value;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if ({1'b0, v_q} >= trial) begin
				v_q <= v_q - trial[SQ_W-1:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[ROOT_W-1:0];

endmodule

@@ rtl/ppto_cordic.sv @@
module ppto_cordic import ppto_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic signed [DIFF_W-1:0] dx,
	input  logic signed [DIFF_W-1:0] dy,
	output logic                     done,
	output logic [HEAD_W-1:0]        angle
);

	cord_phase_t              phase_q;
	logic                     done_q;
	logic signed [CORD_W-1:0] x_q, y_q;
	logic [HEAD_W-1:0]        ang_q;
	logic [3:0]               i_q;
	logic signed [CORD_W-1:0] xe, ye, ax, ay, mag, xs, ys;

	always_comb begin
		xe  = {{(CORD_W-DIFF_W){dx[DIFF_W-1]}}, dx};
		ye  = {{(CORD_W-DIFF_W){dy[DIFF_W-1]}}, dy};
		ax  = x_q[CORD_W-1] ? -x_q : x_q;
		ay  = y_q[CORD_W-1] ? -y_q : y_q;
		mag = (ax > ay) ? ax : ay;
		xs  = x_q >>> i_q;
		ys  = y_q >>> i_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= CS_IDLE;
			done_q  <= 1'b0;
			x_q     <= '0;
			y_q     <= '0;
			ang_q   <= '0;
			i_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				CS_IDLE: begin
					if (go) begin
						if (dx == '0 && dy == '0) begin
							ang_q  <= '0;
							done_q <= 1'b1;
						end else begin
							// fold into the right half plane
							if (dx[DIFF_W-1]) begin
								x_q   <= -xe;
								y_q   <= -ye;
								ang_q <= HALF_TURN;
							end else begin
								x_q   <= xe;
								y_q   <= ye;
								ang_q <= '0;
							end
							phase_q <= CS_NORM;
						end
					end
				end
				CS_NORM: begin
					if ($unsigned(mag) < NORM_FLOOR) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end else begin
						i_q     <= '0;
						phase_q <= CS_ROT;
					end
				end
				CS_ROT: begin
					if (y_q == '0 || i_q == 4'(CORD_STEPS)) begin
						done_q  <= 1'b1;
						phase_q <= CS_IDLE;
					end else begin
						if (!y_q[CORD_W-1]) begin
							x_q   <= x_q + ys;
							y_q   <= y_q - xs;
							ang_q <= ang_q + atan_step(i_q);
						end else begin
							x_q   <= x_q - ys;
							y_q   <= y_q + xs;
							ang_q <= ang_q - atan_step(i_q);
						end
						i_q <= i_q + 4'd1;
					end
				end
				default: phase_q <= CS_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign angle = ang_q;

endmodule

@@ rtl/ppto_blend.sv @@
module ppto_blend import ppto_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [HEAD_W-1:0] from_ang,
	input  logic [HEAD_W-1:0] to_ang,
	input  logic [CUM_W-1:0]  num,
	input  logic [CUM_W-1:0]  den,
	output logic              done,
	output logic [HEAD_W-1:0] result
);

	blend_phase_t      phase_q;
	logic              done_q;
	logic [HEAD_W-1:0] from_q, way_q, q_q, res_q;
	logic              up_q;
	logic [CUM_W-1:0]  num_q, den_q;
	logic [REM_W-1:0]  rem_q;
	logic [3:0]        i_q;
	logic [HEAD_W-1:0] w1, w2, q_nxt;
	logic [REM_W-1:0]  shifted, rem_nxt;
	logic              fits;

	always_comb begin
		w1      = to_ang - from_ang;
		w2      = from_ang - to_ang;
		shifted = {{(REM_W-CUM_W){1'b0}}, den_q} << i_q;
		fits    = rem_q >= shifted;
		rem_nxt = fits ? rem_q - shifted : rem_q;
		q_nxt   = q_q;
		q_nxt[i_q] = fits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= BP_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				BP_IDLE: if (go) phase_q <= BP_MUL;
				BP_MUL: begin
					if (den_q == '0) begin
						done_q  <= 1'b1;
						phase_q <= BP_IDLE;
					end else begin
						phase_q <= BP_DIV;
					end
				end
				BP_DIV: begin
					if (i_q == '0) begin
						done_q  <= 1'b1;
						phase_q <= BP_IDLE;
					end
				end
				default: phase_q <= BP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			BP_IDLE: begin
				if (go) begin
					from_q <= from_ang;
					up_q   <= w1 < w2;
					way_q  <= (w1 < w2) ? w1 : w2;
					num_q  <= num;
					den_q  <= den;
				end
			end
			BP_MUL: begin
				// rounded quotient stays within 16 bits as the weight is at most one
				rem_q <= REM_W'({16'd0, way_q} * {16'd0, num_q})
					+ REM_W'(den_q >> 1);
				q_q   <= '0;
				i_q   <= 4'(HEAD_W - 1);
				res_q <= from_q;
			end
			BP_DIV: begin
				rem_q <= rem_nxt;
				q_q   <= q_nxt;
				i_q   <= i_q - 4'd1;
				if (i_q == '0) res_q <= up_q ? from_q + q_nxt : from_q - q_nxt;
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ rtl/ppto_dp.sv @@
module ppto_dp import ppto_pkg::*; #(
	parameter int MAX_POSES = MAX_POSES_DEF,
	localparam int IW = $clog2(MAX_POSES)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic signed [POS_W-1:0]  in_x,
	input  logic signed [POS_W-1:0]  in_y,
	input  logic [HEAD_W-1:0]        in_h,
	input  logic                     in_last,
	input  ppto_cmd_t                cmd,
	input  logic [IW-1:0]            wr_addr,
	input  logic [IW-1:0]            rd_addr,
	input  logic [OMNI_W-1:0]        blend_num,
	input  logic [OMNI_W-1:0]        omni_den,
	output ppto_stat_t               stat,
	output logic [OMNI_W-1:0]        omni_count,
	output logic signed [POS_W-1:0]  out_x,
	output logic signed [POS_W-1:0]  out_y,
	output logic [HEAD_W-1:0]        out_heading,
	output logic                     out_last,
	output logic                     out_valid,
	input  logic                     out_ready
);

	logic [MS_W-1:0]   min_spacing_q;
	logic [OMNI_W-1:0] omni_count_q;

	logic signed [POS_W-1:0] in_x_q, in_y_q, last_x_q, last_y_q, cur_x_q, cur_y_q;
	logic [HEAD_W-1:0]       in_h_q, start_q, goal_q, target_q, fromr_q;
	logic                    in_last_q;
	logic [CUM_W-1:0]        path_len_q, cur_cum_q;
	logic [SQ_W-1:0]         p1_q, sq_q;
	logic [CUM_W-1:0]        ms2_q;

	logic [2*POS_W-1:0] pose_mem [MAX_POSES];
	logic [CUM_W-1:0]   cum_mem  [MAX_POSES];
	logic [2*POS_W-1:0] rd_pose_q;
	logic [CUM_W-1:0]   rd_cum_q;

	logic signed [POS_W-1:0]  out_x_q, out_y_q;
	logic [HEAD_W-1:0]        out_h_q;
	logic                     out_last_q, out_valid_q;

	logic signed [DIFF_W-1:0] ddx, ddy, cdx, cdy;
	logic signed [POS_W-1:0]  rd_x, rd_y;
	logic [ROOT_W-1:0]        root;
	logic [CUM_W:0]           c_sum;
	logic [CUM_W-1:0]         c_sat, cum_wr;
	logic                     sqrt_done, cord_done, blend_done;
	logic [HEAD_W-1:0]        cord_ang, blend_res, b_from, b_to, head_mux;
	logic [CUM_W-1:0]         b_num, b_den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_spacing_q <= MIN_SPACING_RST;
			omni_count_q  <= OMNI_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_SPACING: min_spacing_q <= cfg_data[MS_W-1:0];
				REG_OMNI_COUNT:  omni_count_q  <= cfg_data[OMNI_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ddx   = DIFF_W'(in_x_q) - DIFF_W'(last_x_q);
		ddy   = DIFF_W'(in_y_q) - DIFF_W'(last_y_q);
		rd_x  = rd_pose_q[POS_W-1:0];
		rd_y  = rd_pose_q[2*POS_W-1:POS_W];
		cdx   = DIFF_W'(rd_x) - DIFF_W'(cur_x_q);
		cdy   = DIFF_W'(rd_y) - DIFF_W'(cur_y_q);
		c_sum = {1'b0, path_len_q} + (CUM_W+1)'(root);
		c_sat = c_sum[CUM_W] ? '1 : c_sum[CUM_W-1:0];
		if (cmd.first)       cum_wr = '0;
		else if (cmd.commit) cum_wr = c_sat;
		else                 cum_wr = path_len_q;
	end

	// blend operand select and output heading select
	always_comb begin
		case (cmd.bsel)
			BL_SHORT: begin
				b_from = start_q;
				b_to   = goal_q;
				b_num  = cur_cum_q;
				b_den  = path_len_q;
			end
			BL_HEAD: begin
				b_from = start_q;
				b_to   = target_q;
				b_num  = CUM_W'(blend_num);
				b_den  = CUM_W'(omni_den);
			end
			default: begin
				b_from = fromr_q;
				b_to   = goal_q;
				b_num  = CUM_W'(blend_num);
				b_den  = CUM_W'(omni_den);
			end
		endcase
		case (cmd.hsel)
			HS_START: head_mux = start_q;
			HS_GOAL:  head_mux = goal_q;
			HS_CORD:  head_mux = cord_ang;
			default:  head_mux = blend_res;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			in_x_q    <= in_x;
			in_y_q    <= in_y;
			in_h_q    <= in_h;
			in_last_q <= in_last;
		end
		if (cmd.sq1) begin
			p1_q  <= SQ_W'(ddx * ddx);
			ms2_q <= CUM_W'(min_spacing_q) * CUM_W'(min_spacing_q);
		end
		if (cmd.sq2) sq_q <= p1_q + SQ_W'(ddy * ddy);
		if (cmd.cap_a) begin
			cur_x_q   <= rd_x;
			cur_y_q   <= rd_y;
			cur_cum_q <= rd_cum_q;
		end
		if (cmd.save_target) target_q <= cord_ang;
		if (cmd.save_fromr)  fromr_q  <= cord_ang;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= '0;
			goal_q     <= '0;
			path_len_q <= '0;
			last_x_q   <= '0;
			last_y_q   <= '0;
		end else begin
			if (cmd.first) begin
				start_q    <= in_h_q;
				path_len_q <= '0;
				last_x_q   <= in_x_q;
				last_y_q   <= in_y_q;
			end
			if (cmd.commit) begin
				path_len_q <= c_sat;
				last_x_q   <= in_x_q;
				last_y_q   <= in_y_q;
			end
			if (cmd.finish || cmd.single_out) goal_q <= in_h_q;
		end
	end

	// pose and distance stores, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.first || cmd.commit || cmd.finish) begin
			pose_mem[wr_addr] <= {in_y_q, in_x_q};
			cum_mem[wr_addr]  <= cum_wr;
		end
		rd_pose_q <= pose_mem[rd_addr];
		rd_cum_q  <= cum_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out || cmd.single_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.single_out) begin
			out_x_q    <= in_x_q;
			out_y_q    <= in_y_q;
			out_h_q    <= in_h_q;
			out_last_q <= 1'b1;
		end else if (cmd.load_out) begin
			out_x_q    <= cur_x_q;
			out_y_q    <= cur_y_q;
			out_h_q    <= head_mux;
			out_last_q <= cmd.out_end;
		end
	end

	ppto_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.sqrt_go),
		.value  (sq_q),
		.done   (sqrt_done),
		.root   (root)
	);

	ppto_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.cord_go),
		.dx     (cdx),
		.dy     (cdy),
		.done   (cord_done),
		.angle  (cord_ang)
	);

	ppto_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.blend_go),
		.from_ang (b_from),
		.to_ang   (b_to),
		.num      (b_num),
		.den      (b_den),
		.done     (blend_done),
		.result   (blend_res)
	);

	always_comb begin
		stat.in_last    = in_last_q;
		stat.too_close  = sq_q < SQ_W'(ms2_q);
		stat.sqrt_done  = sqrt_done;
		stat.cord_done  = cord_done;
		stat.blend_done = blend_done;
		stat.out_busy   = out_valid_q;
	end

	assign omni_count  = omni_count_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_heading = out_h_q;
	assign out_last    = out_last_q;
	assign out_valid   = out_valid_q;

endmodule

@@ rtl/ppto_ctrl.sv @@
module ppto_ctrl import ppto_pkg::*; #(
	parameter int MAX_POSES = MAX_POSES_DEF,
	localparam int IW = $clog2(MAX_POSES),
	localparam int NW = $clog2(MAX_POSES + 1),
	localparam int TW = ((NW > 7) ? NW : 7) + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OMNI_W-1:0] omni_count,
	input  ppto_stat_t        stat,
	output ppto_cmd_t         cmd,
	output logic [IW-1:0]     wr_addr,
	output logic [IW-1:0]     rd_addr,
	output logic [OMNI_W-1:0] blend_num,
	output logic [OMNI_W-1:0] omni_den
);

	localparam logic [IW-1:0] KC_FULL = IW'(MAX_POSES - 1);

	ctrl_state_t       state_q, state_d;
	logic [IW-1:0]     kc_q, k_q;
	logic [NW-1:0]     n_q;
	logic [OMNI_W-1:0] o_q;
	logic              long_q, pre_sel_q;

	logic [OMNI_W-1:0] o_eff;
	logic [NW-1:0]     n_new;
	logic              long_c;
	logic [TW-1:0]     kt, nt, ot, tail_base;
	logic              is_first, is_end, head, tail, use_blend;
	logic [IW-1:0]     pre_a;

	always_comb begin
		o_eff     = (omni_count == '0) ? OMNI_W'(1) : omni_count;
		n_new     = NW'(kc_q) + NW'(1);
		long_c    = TW'(n_new) >= ((TW'(o_eff) << 1) + TW'(2));
		kt        = TW'(k_q);
		nt        = TW'(n_q);
		ot        = TW'(o_q);
		tail_base = nt - ot - TW'(1);
		is_first  = k_q == '0;
		is_end    = kt == nt - TW'(1);
		head      = kt <= ot;
		tail      = kt >= tail_base;
		use_blend = !long_q || head || tail;
		pre_a     = pre_sel_q ? IW'(tail_base) : IW'(o_q);
		blend_num = head ? OMNI_W'(k_q) : OMNI_W'(kt - tail_base);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q      <= '0;
			k_q       <= '0;
			n_q       <= '0;
			o_q       <= OMNI_W'(1);
			long_q    <= 1'b0;
			pre_sel_q <= 1'b0;
		end else begin
			case (state_q)
				ST_DEC: begin
					if (kc_q == '0) begin
						if (!stat.in_last) kc_q <= IW'(1);
					end else if (stat.in_last) begin
						n_q       <= n_new;
						kc_q      <= '0;
						o_q       <= o_eff;
						long_q    <= long_c;
						k_q       <= '0;
						pre_sel_q <= 1'b0;
					end
				end
				ST_COMMIT:   kc_q <= kc_q + IW'(1);
				ST_PRE_CORD: if (stat.cord_done) pre_sel_q <= 1'b1;
				ST_E_WAIT:   if (!stat.out_busy && !is_end) k_q <= k_q + IW'(1);
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		rd_addr  = k_q;
		wr_addr  = kc_q;
		omni_den = o_q;
		cmd.bsel = !long_q ? BL_SHORT : (head ? BL_HEAD : BL_TAIL);
		if (is_first)       cmd.hsel = HS_START;
		else if (is_end)    cmd.hsel = HS_GOAL;
		else if (use_blend) cmd.hsel = HS_BLEND;
		else                cmd.hsel = HS_CORD;
		cmd.out_end = is_end;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.cap_in = in_valid;
				if (in_valid) state_d = ST_DEC;
			end
			ST_DEC: begin
				if (kc_q == '0) begin
					cmd.first = 1'b1;
					if (stat.in_last) begin
						cmd.single_out = 1'b1;
						state_d        = ST_SINGLE;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (!stat.in_last) begin
					state_d = (kc_q >= KC_FULL) ? ST_IDLE : ST_SQ1;
				end else begin
					cmd.finish = 1'b1;
					state_d    = long_c ? ST_PRE_RA : ST_E_RA;
				end
			end
			ST_SQ1: begin
				cmd.sq1 = 1'b1;
				state_d = ST_SQ2;
			end
			ST_SQ2: begin
				cmd.sq2 = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (stat.too_close) begin
					state_d = ST_IDLE;
				end else begin
					cmd.sqrt_go = 1'b1;
					state_d     = ST_SQRT;
				end
			end
			ST_SQRT:   if (stat.sqrt_done) state_d = ST_COMMIT;
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_SINGLE: if (!stat.out_busy) state_d = ST_IDLE;
			ST_PRE_RA: begin
				rd_addr = pre_a;
				state_d = ST_PRE_CA;
			end
			ST_PRE_CA: begin
				cmd.cap_a = 1'b1;
				rd_addr   = pre_a + IW'(1);
				state_d   = ST_PRE_CB;
			end
			ST_PRE_CB: begin
				cmd.cord_go = 1'b1;
				state_d     = ST_PRE_CORD;
			end
			ST_PRE_CORD: begin
				if (stat.cord_done) begin
					if (pre_sel_q) begin
						cmd.save_fromr = 1'b1;
						state_d        = ST_E_RA;
					end else begin
						cmd.save_target = 1'b1;
						state_d         = ST_PRE_RA;
					end
				end
			end
			ST_E_RA: state_d = ST_E_CA;
			ST_E_CA: begin
				cmd.cap_a = 1'b1;
				if (is_first || is_end) begin
					state_d = ST_E_LOAD;
				end else if (use_blend) begin
					state_d = ST_E_BST;
				end else begin
					rd_addr = k_q + IW'(1);
					state_d = ST_E_CB;
				end
			end
			ST_E_CB: begin
				cmd.cord_go = 1'b1;
				state_d     = ST_E_CORD;
			end
			ST_E_CORD: if (stat.cord_done) state_d = ST_E_LOAD;
			ST_E_BST: begin
				cmd.blend_go = 1'b1;
				state_d      = ST_E_DIV;
			end
			ST_E_DIV:  if (stat.blend_done) state_d = ST_E_LOAD;
			ST_E_LOAD: begin
				cmd.load_out = 1'b1;
				state_d      = ST_E_WAIT;
			end
			ST_E_WAIT: begin
				if (!stat.out_busy) state_d = is_end ? ST_IDLE : ST_E_RA;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ test/path_pose_thin_and_orient_tb.sv @@
`timescale 1ns / 1ps

// path loader check: poses stream in, on the last pose every kept pose streams out
// with its assigned heading; a scoreboard mirrors the thinning and heading rules
module path_pose_thin_and_orient_tb;
	import ppto_pkg::*;

	// mirror of the path store and the heading rules
	class pose_scoreboard;
		int atan_tab[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
		logic [15:0] min_spacing = 16'd51;
		logic [4:0]  omni = 5'd20;
		logic [47:0] poses[64];
		logic [31:0] cum[64];
		int          kept = 0;
		logic [15:0] start_ang = '0, goal_ang = '0;
		logic [31:0] plen = '0;
		logic [64:0] emitted_q[$];   // {last, heading, y, x}
		int          errors = 0, checked = 0, paths = 0;

		function void expect_pose(logic [64:0] e);
			emitted_q = {emitted_q, e};
		endfunction

		function longint sx(logic [23:0] v);
			return longint'(signed'(v));
		endfunction

		function longint root_of(longint s);
			longint r, t;
			r = 0;
			for (int b = 24; b >= 0; b--) begin
				t = r | (longint'(1) << b);
				if (t * t <= s) r = t;
			end
			return r;
		endfunction

		// cordic vectoring, turned into the right half plane first
		function logic [15:0] heading_of(longint x, longint y);
			longint ax, ay, m, xs, ys;
			int ang;
			ang = 0;
			if (x == 0 && y == 0) return 16'd0;
			if (x < 0) begin
				x = -x; y = -y; ang = 32768;
			end
			ax = x;
			ay = y < 0 ? -y : y;
			m = ax > ay ? ax : ay;
			while (m < (longint'(1) << 29)) begin
				x *= 2; y *= 2; m *= 2;
			end
			for (int i = 0; i < 15 && y != 0; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x += ys; y -= xs; ang += atan_tab[i];
				end else begin
					x -= ys; y += xs; ang -= atan_tab[i];
				end
			end
			return ang[15:0];
		endfunction

		function logic [15:0] segment_heading(int a, int b);
			return heading_of(sx(poses[b][23:0]) - sx(poses[a][23:0]),
				sx(poses[b][47:24]) - sx(poses[a][47:24]));
		endfunction

		// turn the short way from one angle toward another by num/den
		function logic [15:0] turn_toward(logic [15:0] from, logic [15:0] to,
				longint num, longint den);
			logic [15:0] w1, w2;
			longint way, off;
			w1 = to - from;
			w2 = from - to;
			way = w1 < w2 ? longint'(w1) : longint'(w2);
			off = 0;
			if (den != 0) off = (way * num + den / 2) / den;
			return w1 < w2 ? from + off[15:0] : from - off[15:0];
		endfunction

		function void note_pose(logic [23:0] x, logic [23:0] y, logic [15:0] h, bit last);
			longint dx, dy, s, c;
			int n, o;
			logic [15:0] target, fromr, hd;
			if (kept == 0) begin
				start_ang = h;
				poses[0] = {y, x};
				cum[0] = '0;
				plen = '0;
				if (!last) begin
					kept = 1;
					return;
				end
				paths++;
				expect_pose({1'b1, h, y, x});
				return;
			end
			if (!last) begin
				if (kept >= 63) return;
				dx = sx(x) - sx(poses[kept-1][23:0]);
				dy = sx(y) - sx(poses[kept-1][47:24]);
				s = dx * dx + dy * dy;
				if (s < longint'(min_spacing) * longint'(min_spacing)) return;
				c = longint'(cum[kept-1]) + root_of(s);
				if (c > 64'hFFFFFFFF) c = 64'hFFFFFFFF;
				poses[kept] = {y, x};
				cum[kept] = c[31:0];
				plen = c[31:0];
				kept++;
				return;
			end
			goal_ang = h;
			poses[kept] = {y, x};
			cum[kept] = plen;
			n = kept + 1;
			kept = 0;
			paths++;
			o = omni == 0 ? 1 : int'(omni);
			target = '0;
			fromr = '0;
			if (n >= 2 * o + 2) begin
				target = segment_heading(o, o + 1);
				fromr = segment_heading(n - o - 1, n - o);
			end
			for (int k = 0; k < n; k++) begin
				if (k == 0) hd = start_ang;
				else if (k == n - 1) hd = goal_ang;
				else if (n < 2 * o + 2)
					hd = turn_toward(start_ang, goal_ang, longint'(cum[k]), longint'(plen));
				else if (k <= o) hd = turn_toward(start_ang, target, longint'(k), longint'(o));
				else if (k >= n - o - 1)
					hd = turn_toward(fromr, goal_ang, longint'(k - (n - o - 1)), longint'(o));
				else hd = segment_heading(k, k + 1);
				expect_pose({k == n - 1, hd, poses[k]});
			end
		endfunction

		function void check_result(logic [63:0] d, logic l);
			logic [64:0] e;
			checked++;
			if (emitted_q.size() == 0) begin
				$display("%0t unexpected pose out: x=%h y=%h heading=%h last=%b",
					$time, d[23:0], d[47:24], d[63:48], l);
				errors++;
				return;
			end
			e = emitted_q.pop_front();
			if (d[23:0] !== e[23:0]) begin
				$display("%0t out_x mismatch: expected %h actual %h", $time, e[23:0], d[23:0]);
				errors++;
			end
			if (d[47:24] !== e[47:24]) begin
				$display("%0t out_y mismatch: expected %h actual %h", $time, e[47:24], d[47:24]);
				errors++;
			end
			if (d[63:48] !== e[63:48]) begin
				$display("%0t out_heading mismatch: expected %h actual %h",
					$time, e[63:48], d[63:48]);
				errors++;
			end
			if (l !== e[64]) begin
				$display("%0t out_last mismatch: expected %b actual %b", $time, e[64], l);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  cfg_we = 0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 0;
	logic                  s_axis_tready;
	logic [63:0]           s_axis_tdata = '0;  // pos_x[23:0], pos_y[47:24], heading[63:48]
	logic                  s_axis_tlast = 0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 0;
	logic [63:0]           m_axis_tdata;       // out_x[23:0], out_y[47:24], out_heading[63:48]
	logic                  m_axis_tlast;

	pose_scoreboard sb = new();
	int items = 0;
	int burst_left = 1;
	int hold_asks = 0;   // bumped by the sender to ask for a long receiver stall

	path_pose_thin_and_orient dut (.*);

	initial forever #5 clk = ~clk;

	// every accepted output transfer is checked against the oldest expected pose
	always @(posedge clk)
		if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);

	// receiver: phases of always-ready, random and mostly-stalled, plus long hold-offs
	initial begin
		int hold_done, hold_cnt, phase_cnt, mode;
		hold_done = 0;
		hold_cnt = 0;
		phase_cnt = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 1'b0;
			end else if (hold_done != hold_asks) begin
				hold_done = hold_asks;
				hold_cnt = 300;
				m_axis_tready <= 1'b0;
			end else begin
				if (phase_cnt == 0) begin
					phase_cnt = $urandom_range(20, 80);
					mode = $urandom_range(0, 2);
				end
				phase_cnt--;
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// one pose transfer; valid stays up inside a burst, drops for a gap after it
	task automatic send_pose(logic [23:0] x, logic [23:0] y, logic [15:0] h, bit last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {h, y, x};
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_pose(x, y, h, last);
		items++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// wait until every expected pose is out and the block has settled
	task automatic drain();
		int guard;
		guard = 0;
		s_axis_tvalid <= 1'b0;
		while (sb.emitted_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MIN_SPACING) sb.min_spacing = val;
		else sb.omni = val[4:0];
	endtask

	// random walk path; wild paths jump anywhere, repeated points test the dropping
	task automatic run_path(int n, int step, bit wild);
		logic [23:0] x, y;
		x = 24'($urandom);
		y = 24'($urandom);
		send_pose(x, y, 16'($urandom), n == 1);
		for (int i = 1; i < n; i++) begin
			if (wild) begin
				x = 24'($urandom);
				y = 24'($urandom);
			end else if ($urandom_range(0, 5) != 0) begin
				x = x + 24'(int'($urandom_range(0, 2 * step)) - step);
				y = y + 24'(int'($urandom_range(0, 2 * step)) - step);
			end
			send_pose(x, y, 16'($urandom), i == n - 1);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-pose paths at the coordinate extremes, reset register values
		send_pose(24'h7FFFFF, 24'h800000, 16'hFFFF, 1'b1);
		send_pose(24'h800000, 24'h7FFFFF, 16'h0000, 1'b1);
		drain();

		// zero path length: coincident poses all kept, interior keeps start yaw
		write_reg(REG_MIN_SPACING, 16'd0);
		write_reg(REG_OMNI_COUNT, 16'd2);
		for (int i = 0; i < 4; i++) send_pose(24'h000100, 24'hFFFF00, 16'h1234, i == 3);
		drain();

		// widest spacing with far-flung poses, omni count zero treated as one
		write_reg(REG_MIN_SPACING, 16'hFFFF);
		write_reg(REG_OMNI_COUNT, 16'd0);
		send_pose(24'h800000, 24'h800000, 16'h4000, 1'b0);
		send_pose(24'h800010, 24'h800000, 16'h0000, 1'b0);
		send_pose(24'h7FFFFF, 24'h7FFFFF, 16'h0000, 1'b0);
		send_pose(24'h000000, 24'h7FFFFF, 16'h0000, 1'b0);
		send_pose(24'h800000, 24'h000000, 16'h0000, 1'b0);
		send_pose(24'h000000, 24'h000000, 16'hC000, 1'b1);
		drain();

		// short path with poses right at the spacing threshold
		write_reg(REG_MIN_SPACING, 16'd5);
		write_reg(REG_OMNI_COUNT, 16'd31);
		send_pose(24'h0, 24'h0, 16'h7000, 1'b0);
		send_pose(24'd3, 24'd4, 16'h0, 1'b0);
		send_pose(24'd5, 24'd7, 16'h0, 1'b0);
		send_pose(24'd12, 24'd4, 16'h0, 1'b0);
		send_pose(24'd12, 24'd0, 16'h9000, 1'b1);
		drain();

		// store overflow with the largest blend span, receiver holds off on the way out
		write_reg(REG_MIN_SPACING, 16'd1);
		run_path(72, 3000, 1'b0);
		hold_asks++;
		run_path(3, 500, 1'b0);   // offered while the output is held
		drain();

		while (items < 155) begin
			if ($urandom_range(0, 1) == 0) begin
				drain();
				case ($urandom_range(0, 4))
					0: write_reg(REG_MIN_SPACING, 16'd0);
					1: write_reg(REG_MIN_SPACING, 16'hFFFF);
					2: write_reg(REG_MIN_SPACING, 16'($urandom));
					default: write_reg(REG_MIN_SPACING, 16'($urandom_range(1, 120)));
				endcase
				write_reg(REG_OMNI_COUNT, ($urandom_range(0, 4) == 0)
					? 16'($urandom_range(0, 31)) : 16'($urandom_range(1, 4)));
			end
			if ($urandom_range(0, 9) == 0) hold_asks++;
			if ($urandom_range(0, 7) == 0) run_path($urandom_range(2, 6), 0, 1'b1);
			else run_path($urandom_range(1, 16), $urandom_range(10, 400), 1'b0);
			if ($urandom_range(0, 2) == 0) drain();
		end
		drain();

		$display("covered %0d input poses over %0d paths, %0d output poses checked",
			items, sb.paths, sb.checked);
		if (sb.errors == 0 && sb.emitted_q.size() == 0) begin
			$display("path_pose_thin_and_orient_tb OK");
		end else begin
			$display("%0t %0d mismatches, %0d expected poses never came", $time, sb.errors,
				sb.emitted_q.size());
			$display("path_pose_thin_and_orient_tb NOT OK");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("path_pose_thin_and_orient_tb NOT OK");
		$finish;
	end

endmodule
